// ----- rtl/graph_segmentation_merge_assert.svh -----
// Assertion macros shared by the graph segmentation merge RTL.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef GRAPH_SEGMENTATION_MERGE_ASSERT_SVH
`define GRAPH_SEGMENTATION_MERGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gsm_pkg.sv -----
// Package for the graph segmentation merge block: widths, codes and reset constants.
// No dependencies.
package gsm_pkg;
    localparam int K_W              = 24;      // threshold register width
    localparam int W_W              = 13;      // Q9.4 edge weight width
    localparam int FRAC_BITS        = 4;
    localparam int TOL_W            = 25;      // integer tolerance width
    localparam int NUM_VERTICES_DEF = 65536;
    localparam logic [K_W-1:0] K_RESET = 24'd1500000;

    // item kinds carried on tuser of the input stream
    localparam logic MODE_EDGE  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
endpackage

// ----- rtl/gsm_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
module gsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/gsm_div.sv -----
// Restoring divider, one quotient bit per cycle: threshold K over a set size.
// Depends on gsm_pkg and graph_segmentation_merge_assert.svh.
`include "graph_segmentation_merge_assert.svh"
module gsm_div #(
    parameter int SW = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [gsm_pkg::K_W-1:0] i_dividend,
    input  logic [SW-1:0]         i_divisor,
    output logic                  o_done,
    output logic [gsm_pkg::K_W-1:0] o_quot
);
    import gsm_pkg::*;
    localparam int CW = $clog2(K_W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rem;
    logic [K_W-1:0] r_quo;
    logic [SW-1:0] r_den;
    logic [SW:0]   sh;
    logic          fits;

    // shift in the next dividend bit and try the subtraction
    assign sh   = {r_rem, r_quo[K_W-1]};
    assign fits = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(K_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? SW'(sh - {1'b0, r_den}) : SW'(sh);
                r_quo <= {r_quo[K_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    `GSM_ASSERT_NEXT(a_div_start_busy, i_start, r_busy, "divider did not start")
    `GSM_ASSERT_NOW(a_div_done_idle, r_done, !r_busy, "divider done while busy")
    `GSM_ASSERT_NOW(a_div_cnt_range, r_busy, r_cnt != '0, "divider count ran out while busy")
endmodule

// ----- rtl/graph_segmentation_merge.sv -----
// Top level of the graph segmentation merge block: sequencer over a union-find RAM.
// Depends on gsm_pkg, gsm_ram, gsm_div and graph_segmentation_merge_assert.svh.
//
// channel   | direction | payload
// s_axis    | in        | tuser: mode; tdata: vertex_a, vertex_b, edge_weight
// m_axis    | out       | tuser: merged; tdata: root_label, component_size, component_count
// cfg       | in        | wdata: threshold_k
//
// Each root find walks the parent chain one vertex at a time, a read state and a check
// state per vertex (one RAM read port). An edge with distinct roots adds two divisions
// (start, shift-subtract steps, done), a test and, if it passes, two RAM writes; a
// query needs only the root find of vertex_a.
// After reset a clearing pass writes the RAM entry of every vertex, with no
// input taken. A waiting result is held in the output register; one new item is
// taken while it waits, and its own result waits for the register to free up.
`include "graph_segmentation_merge_assert.svh"
module graph_segmentation_merge #(
    parameter int NUM_VERTICES = gsm_pkg::NUM_VERTICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // vertex_a[15:0], vertex_b[31:16], edge_weight[44:32]
    input  logic        i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // root_label[15:0], component_size[32:16],
                                          // component_count[49:33]
    output logic        o_m_axis_tuser,   // merged
    input  logic        i_cfg_we,
    input  logic [gsm_pkg::K_W-1:0] i_cfg_wdata
);
    import gsm_pkg::*;
    localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int SW = VW + 1;
    localparam int WW = VW + SW + W_W;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FA_RD, ST_FA_CHK, ST_FB_RD, ST_FB_CHK,
        ST_DIVU_GO, ST_DIVU_W, ST_DIVV_GO, ST_DIVV_W, ST_TEST,
        ST_WR_GONE, ST_WR_KEEP, ST_OUT
    } t_state;

    t_state         r_state;
    logic [VW-1:0]  r_clr;
    logic [K_W-1:0] r_threshold_k;
    logic [SW-1:0]  r_sets_left;
    logic           r_mode;
    logic           r_b_ok;
    logic [VW-1:0]  r_b;
    logic [W_W-1:0] r_w;
    logic [VW-1:0]  r_cur;
    logic [VW-1:0]  r_ra, r_rb, r_keep, r_gone;
    logic [SW-1:0]  r_size_a, r_size_b, r_gone_size, r_sum;
    logic [W_W-1:0] r_max_a, r_max_b, r_gone_max, r_mmax;
    logic [TOL_W-1:0] r_tu, r_tv;
    logic [15:0]    r_res_root;
    logic [16:0]    r_res_size;
    logic           r_res_merged;
    logic           r_out_valid;
    logic [55:0]    r_out_data;
    logic           r_out_user;

    logic           ram_we, ram_re;
    logic [VW-1:0]  ram_waddr;
    logic [WW-1:0]  ram_wdata, ram_rdata;
    logic [VW-1:0]  rd_par;
    logic [SW-1:0]  rd_size;
    logic [W_W-1:0] rd_max;
    logic           div_start, div_done;
    logic [K_W-1:0] div_quot;
    logic [TOL_W-1:0] tol_min;
    logic           in_xfer, a_ok, b_ok, pass;
    logic [TOL_W-1:0] div_tol;

    assign rd_par  = ram_rdata[WW-1 -: VW];
    assign rd_size = ram_rdata[W_W +: SW];
    assign rd_max  = ram_rdata[W_W-1:0];

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign a_ok    = 32'(i_s_axis_tdata[15:0]) < NUM_VERTICES;
    assign b_ok    = 32'(i_s_axis_tdata[31:16]) < NUM_VERTICES;
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // tolerance from the divider and the joining test
    assign div_tol = TOL_W'(div_quot) +
                     TOL_W'((r_state == ST_DIVU_W ? r_max_a : r_max_b) >> FRAC_BITS);
    assign tol_min = (r_tu < r_tv) ? r_tu : r_tv;
    assign pass    = (29'(r_w) <= {tol_min, 4'b0000});

    assign div_start = (r_state == ST_DIVU_GO) || (r_state == ST_DIVV_GO);

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = {r_clr, SW'(1), W_W'(0)};
        ram_re    = 1'b0;
        unique case (r_state)
            ST_CLEAR: ram_we = 1'b1;
            ST_FA_RD, ST_FB_RD: ram_re = 1'b1;
            ST_WR_GONE: begin
                ram_we    = 1'b1;
                ram_waddr = r_gone;
                ram_wdata = {r_keep, r_gone_size, r_gone_max};
            end
            ST_WR_KEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_keep;
                ram_wdata = {r_keep, r_sum, r_mmax};
            end
            default: ram_re = 1'b0;
        endcase
    end

    gsm_ram #(.WIDTH(WW), .DEPTH(2 ** VW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_cur),
        .o_rdata (ram_rdata)
    );

    gsm_div #(.SW(SW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_threshold_k),
        .i_divisor  (r_state == ST_DIVU_GO ? r_size_a : r_size_b),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // sequencer, registers and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr         <= '0;
            r_threshold_k <= K_RESET;
            r_sets_left   <= SW'(NUM_VERTICES);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold_k <= i_cfg_wdata;
            end
            // drop the output once taken, unless a new result reloads it
            if (o_m_axis_tvalid && i_m_axis_tready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == VW'(NUM_VERTICES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_mode       <= i_s_axis_tuser;
                        r_b_ok       <= b_ok;
                        r_b          <= VW'(i_s_axis_tdata[31:16]);
                        r_w          <= i_s_axis_tdata[44:32];
                        r_cur        <= VW'(i_s_axis_tdata[15:0]);
                        r_res_merged <= 1'b0;
                        if (a_ok) begin
                            r_state <= ST_FA_RD;
                        end else begin
                            r_res_root <= i_s_axis_tdata[15:0];
                            r_res_size <= 17'd1;
                            r_state    <= ST_OUT;
                        end
                    end
                end
                ST_FA_RD, ST_FB_RD: begin
                    r_state <= (r_state == ST_FA_RD) ? ST_FA_CHK : ST_FB_CHK;
                end
                ST_FA_CHK: begin
                    if (rd_par != r_cur) begin
                        r_cur   <= rd_par;
                        r_state <= ST_FA_RD;
                    end else begin
                        r_ra       <= r_cur;
                        r_size_a   <= rd_size;
                        r_max_a    <= rd_max;
                        r_res_root <= 16'(r_cur);
                        r_res_size <= 17'(rd_size);
                        if (r_mode == MODE_EDGE && r_b_ok) begin
                            r_cur   <= r_b;
                            r_state <= ST_FB_RD;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_FB_CHK: begin
                    if (rd_par != r_cur) begin
                        r_cur   <= rd_par;
                        r_state <= ST_FB_RD;
                    end else begin
                        r_rb     <= r_cur;
                        r_size_b <= rd_size;
                        r_max_b  <= rd_max;
                        r_state  <= (r_cur == r_ra) ? ST_OUT : ST_DIVU_GO;
                    end
                end
                ST_DIVU_GO: r_state <= ST_DIVU_W;
                ST_DIVU_W: begin
                    if (div_done) begin
                        r_tu    <= div_tol;
                        r_state <= ST_DIVV_GO;
                    end
                end
                ST_DIVV_GO: r_state <= ST_DIVV_W;
                ST_DIVV_W: begin
                    if (div_done) begin
                        r_tv    <= div_tol;
                        r_state <= ST_TEST;
                    end
                end
                ST_TEST: begin
                    if (pass) begin
                        // larger set keeps its root; on a tie u goes under v
                        if (r_size_a > r_size_b) begin
                            r_keep      <= r_ra;
                            r_gone      <= r_rb;
                            r_gone_size <= r_size_b;
                            r_gone_max  <= r_max_b;
                            r_res_root  <= 16'(r_ra);
                        end else begin
                            r_keep      <= r_rb;
                            r_gone      <= r_ra;
                            r_gone_size <= r_size_a;
                            r_gone_max  <= r_max_a;
                            r_res_root  <= 16'(r_rb);
                        end
                        r_sum      <= SW'(r_size_a + r_size_b);
                        r_res_size <= 17'(SW'(r_size_a + r_size_b));
                        r_mmax     <= (r_max_a > r_max_b) ?
                                      ((r_max_a > r_w) ? r_max_a : r_w) :
                                      ((r_max_b > r_w) ? r_max_b : r_w);
                        r_res_merged <= 1'b1;
                        r_state      <= ST_WR_GONE;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_WR_GONE: r_state <= ST_WR_KEEP;
                ST_WR_KEEP: begin
                    if (r_sets_left != '0) begin
                        r_sets_left <= r_sets_left - 1'b1;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // load the output register once it is free
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_res_merged;
                        r_out_data  <= {6'b0, 17'(r_sets_left), r_res_size, r_res_root};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    `GSM_ASSERT_NOW(a_keep_ne_gone, r_state == ST_WR_GONE, r_keep != r_gone, "self merge")
    `GSM_ASSERT_NOW(a_sets_left_nz, 1'b1, r_sets_left != '0, "no sets left")
    `GSM_ASSERT_NEXT(a_keep_after_gone, r_state == ST_WR_GONE, r_state == ST_WR_KEEP,
        "merge write pair broken")
    `GSM_ASSERT_NOW(a_div_only_tested, div_done, r_state == ST_DIVU_W || r_state == ST_DIVV_W,
        "quotient arrived outside a wait state")
endmodule

// ----- sim/graph_segmentation_merge_checker.sv -----
// Checker for the graph segmentation merge block: watches the input, output and
// register channels, predicts each result from a union-find table and compares.
// Depends on gsm_pkg.
module graph_segmentation_merge_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    input  logic                    i_s_axis_tready,
    input  logic [47:0]             i_s_axis_tdata,   // vertex_a, vertex_b, edge_weight
    input  logic                    i_s_axis_tuser,   // mode
    input  logic                    i_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    input  logic [55:0]             i_m_axis_tdata,   // root_label, component_size,
                                                      // component_count
    input  logic                    i_m_axis_tuser,   // merged
    input  logic                    i_cfg_we,
    input  logic [gsm_pkg::K_W-1:0] i_cfg_wdata,
    output int                      o_fail_count,
    output int                      o_pending
);
    import gsm_pkg::*;

    localparam int NV = NUM_VERTICES_DEF;

    typedef struct packed {
        logic        merged;
        logic [15:0] root_label;
        logic [16:0] comp_size;
        logic [16:0] comp_count;
    } t_segment_result;

    logic [15:0]    parent_of [NV];
    logic [16:0]    size_of   [NV];
    logic [W_W-1:0] max_of    [NV];
    logic [16:0]    sets_left;
    logic [K_W-1:0] k_value;
    bit             tables_ready;
    t_segment_result expected_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        tables_ready = 0;
    end

    // Walk the parent chain up to the set root.
    function automatic int find_root(int v);
        while (parent_of[v] != v[15:0])
            v = parent_of[v];
        return v;
    endfunction

    // Integer merge tolerance of a set: floor(max) + K / size.
    function automatic longint unsigned set_tolerance(int r);
        longint unsigned sz;
        sz = (size_of[r] == 0) ? 1 : size_of[r];
        return longint'(max_of[r] >> FRAC_BITS) + longint'(k_value) / sz;
    endfunction

    // Apply one item to the table and return its result.
    function automatic t_segment_result merge_edge(logic mode, int a, int b,
                                                   logic [W_W-1:0] w);
        t_segment_result res;
        int              ru, rv, keep, gone;
        longint unsigned tu, tv, t;
        logic [W_W-1:0]  m;
        res = '0;
        if (mode == MODE_EDGE) begin
            ru = find_root(a);
            rv = find_root(b);
            if (ru != rv) begin
                tu = set_tolerance(ru);
                tv = set_tolerance(rv);
                t  = (tu < tv) ? tu : tv;
                if (longint'(w) <= (t << FRAC_BITS)) begin
                    if (size_of[ru] > size_of[rv]) begin
                        keep = ru; gone = rv;
                    end else begin
                        keep = rv; gone = ru;
                    end
                    size_of[keep]   = size_of[keep] + size_of[gone];
                    parent_of[gone] = keep[15:0];
                    m = max_of[keep];
                    if (max_of[gone] > m) m = max_of[gone];
                    if (w > m) m = w;
                    max_of[keep] = m;
                    if (sets_left != 0) sets_left = sets_left - 1;
                    res.merged = 1'b1;
                end
            end
        end
        ru = find_root(a);
        res.root_label = ru[15:0];
        res.comp_size  = size_of[ru];
        res.comp_count = sets_left;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_segment_result exp_r, got_r;
        if (!i_rst_n) begin
            if (!tables_ready) begin
                for (int i = 0; i < NV; i++) begin
                    parent_of[i] = i[15:0];
                    size_of[i]   = 17'd1;
                    max_of[i]    = '0;
                end
                sets_left    = 17'(NV);
                k_value      = K_RESET;
                tables_ready = 1;
            end
        end else begin
            if (i_cfg_we)
                k_value = i_cfg_wdata;
            // Compare each output transfer with the oldest prediction.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_r = {i_m_axis_tuser, i_m_axis_tdata[15:0], i_m_axis_tdata[32:16],
                         i_m_axis_tdata[49:33]};
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected result %p", got_r);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r !== exp_r) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("ERROR: expected %p, got %p", exp_r, got_r);
                    end
                end
            end
            // Predict the result of each input transfer.
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_q.push_back(merge_edge(i_s_axis_tuser,
                    int'(i_s_axis_tdata[15:0]), int'(i_s_axis_tdata[31:16]),
                    i_s_axis_tdata[44:32]));
        end
        o_pending = expected_q.size();
    end
endmodule

// ----- sim/graph_segmentation_merge_tb.sv -----
// Testbench top for the graph segmentation merge block: clock, reset, stimulus
// with random idling, register writes between phases and the verdict.
// Depends on gsm_pkg, graph_segmentation_merge and graph_segmentation_merge_checker.
module graph_segmentation_merge_tb;
    import gsm_pkg::*;

    localparam logic [W_W-1:0] W_MAX = '1;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [47:0]    s_tdata = '0;
    logic           s_tuser = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [55:0]    m_tdata;
    logic           m_tuser;
    logic           cfg_we = 1'b0;
    logic [K_W-1:0] cfg_wdata = '0;
    int             fail_count;
    int             pending;
    int             send_idle_pct;
    int             recv_stall_pct;
    logic [W_W-1:0] cur_weight;

    graph_segmentation_merge u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    graph_segmentation_merge_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the output side at random.
    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Drive one input transfer, idling first at random; returns at a falling edge.
    task automatic send_item(logic mode, logic [15:0] a, logic [15:0] b,
                             logic [W_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b0, w, b, a};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // Drain all results, let the block settle, then write the threshold.
    task automatic write_threshold(logic [K_W-1:0] k);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly ascending edges inside a small vertex pool, with queries and noise.
    task automatic random_phase(int n_items);
        logic [15:0] pool_base, a, b;
        int          pool_sz, pick;
        logic        mode;
        logic [W_W-1:0] w;
        pool_base  = 16'($urandom);
        pool_sz    = $urandom_range(16, 128);
        cur_weight = '0;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            mode = (pick < 12) ? MODE_QUERY : MODE_EDGE;
            a = pool_base + 16'($urandom_range(pool_sz - 1));
            b = pool_base + 16'($urandom_range(pool_sz - 1));
            if (pick >= 90) begin
                a = 16'($urandom);
                b = 16'($urandom);
            end
            if (cur_weight < W_MAX - 8) cur_weight = cur_weight + W_W'($urandom_range(8));
            w = (pick >= 95) ? W_W'($urandom) : cur_weight;
            send_item(mode, a, b, w);
        end
    endtask

    initial begin
        send_idle_pct  = 10;
        recv_stall_pct = 63;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, queries, repeated and self edges at the reset threshold.
        send_item(MODE_QUERY, 16'd0, 16'hFFFF, W_MAX);
        send_item(MODE_EDGE,  16'd0, 16'hFFFF, 13'd0);
        send_item(MODE_EDGE,  16'hFFFF, 16'd0, 13'd1);
        send_item(MODE_EDGE,  16'd7, 16'd7, 13'd2);
        send_item(MODE_EDGE,  16'd1, 16'd0, 13'd3);
        send_item(MODE_QUERY, 16'hFFFF, 16'd0, 13'd0);
        send_item(MODE_EDGE,  16'hAAAA, 16'h5555, W_MAX);
        send_item(MODE_EDGE,  16'h5555, 16'hFFFF, W_MAX);
        send_item(MODE_QUERY, 16'hAAAA, 16'h1234, 13'h0AAA);

        // Zero threshold: only weights within floor(max) pass.
        write_threshold('0);
        send_item(MODE_EDGE,  16'd100, 16'd101, 13'd0);
        send_item(MODE_EDGE,  16'd102, 16'd103, 13'd1);
        send_item(MODE_EDGE,  16'd100, 16'hFFFF, 13'd15);
        send_item(MODE_EDGE,  16'd103, 16'd100, 13'd0);
        send_item(MODE_QUERY, 16'd103, 16'd0, 13'd0);

        write_threshold('1);
        random_phase(700);

        send_idle_pct  = 63;
        recv_stall_pct = 10;
        write_threshold(K_W'($urandom_range(50, 3000)));
        random_phase(700);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_threshold(K_W'($urandom_range(1000, 100000)));
        random_phase(600);

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog.
    initial begin
        #50000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
